// File: rtl/two_level_exclusive_cache_tags_assert.svh
// ----------------------------------------------------------------------------
// two-level exclusive cache tags: assertion macros
// shared property forms used by the block's modules
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_EXCLUSIVE_CACHE_TAGS_ASSERT_SVH
`define TWO_LEVEL_EXCLUSIVE_CACHE_TAGS_ASSERT_SVH

// same-cycle implication
`define TEC_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("tec assertion failed");

// next-cycle implication
`define TEC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("tec assertion failed");

`endif

// File: rtl/tec_pkg.sv
// ----------------------------------------------------------------------------
// tec_pkg
// shared constants, types and geometry helper of the cache tag block
// ----------------------------------------------------------------------------
package tec_pkg;

    localparam int DEF_L1_LINES  = 256;
    localparam int DEF_L2_LINES  = 1024;
    localparam int DEF_ADDR_BITS = 32;

    localparam int OFF_W      = 4;
    localparam int IDX_W      = 4;
    localparam int L1_WAYS_W  = 9;
    localparam int L2_WAYS_W  = 11;
    localparam int WAYS_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int STAT_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_L1_OFF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_IDX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_WAYS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_OFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_IDX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_FA   = 3'd6;

    localparam logic [STAT_W-1:0] ST_NONE       = 3'd0;
    localparam logic [STAT_W-1:0] ST_READ_HIT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_READ_MISS  = 3'd2;
    localparam logic [STAT_W-1:0] ST_WRITE_HIT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_WRITE_MISS = 3'd4;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [IDX_W-1:0]  idx;
        logic [WAYS_W-1:0] ways;
    } geo_t;

    typedef struct packed {
        geo_t g1;
        geo_t g2;
        logic fa;
    } cfg_geo_t;

    // clamp ways to 1..cap and lower index bits until sets times ways fits
    function automatic geo_t make_geo(input logic [OFF_W-1:0] off,
                                      input logic [IDX_W-1:0] idx,
                                      input logic [WAYS_W-1:0] ways,
                                      input int unsigned cap);
        geo_t g;
        logic [31:0] w;
        logic [IDX_W-1:0] r;
        w = (ways == '0) ? 32'd1 : {21'd0, ways};
        if (w > cap) w = cap;
        r = '0;
        for (int k = 0; k < 16; k++) begin
            if ((IDX_W'(k) <= idx) && ((w << k) <= cap)) r = IDX_W'(k);
        end
        g.off  = off;
        g.idx  = r;
        g.ways = w[WAYS_W-1:0];
        return g;
    endfunction

endpackage

// File: rtl/tec_ram.sv
// ----------------------------------------------------------------------------
// tec_ram
// generic simple dual-port ram, one write and one registered read
// ----------------------------------------------------------------------------
module tec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

// File: rtl/tec_front.sv
// ----------------------------------------------------------------------------
// tec_front
// configuration registers, geometry and address split of each access
// ----------------------------------------------------------------------------
module tec_front #(
    parameter int L1_LINES  = 256,
    parameter int L2_LINES  = 1024,
    parameter int ADDR_BITS = 32,
    parameter int A1        = 8,
    parameter int A2        = 10,
    parameter int ITEM_W    = 1 + 2 * ADDR_BITS + 2 * A1 + A2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr,
    input  logic [tec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tec_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                         req_type,
    input  logic [31:0]                  addr,
    output logic [ITEM_W-1:0]            item,
    output tec_pkg::cfg_geo_t            geo,
    output logic                         geo_ok
);
    import tec_pkg::*;

    logic [OFF_W-1:0]     l1_off_reg, l2_off_reg;
    logic [IDX_W-1:0]     l1_idx_reg, l2_idx_reg;
    logic [L1_WAYS_W-1:0] l1_ways_reg;
    logic [L2_WAYS_W-1:0] l2_ways_reg;
    logic                 l2_fa_reg;
    cfg_geo_t             geo_reg;
    logic                 geo_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_off_reg  <= 4'd6;
            l1_idx_reg  <= 4'd6;
            l1_ways_reg <= 9'd4;
            l2_off_reg  <= 4'd6;
            l2_idx_reg  <= 4'd8;
            l2_ways_reg <= 11'd4;
            l2_fa_reg   <= 1'b0;
            geo_ok_reg  <= 1'b0;
        end else begin
            geo_ok_reg <= !cfg_wr;
            if (cfg_wr) begin
                unique case (cfg_index)
                    CFG_L1_OFF:  l1_off_reg  <= cfg_data[OFF_W-1:0];
                    CFG_L1_IDX:  l1_idx_reg  <= cfg_data[IDX_W-1:0];
                    CFG_L1_WAYS: l1_ways_reg <= cfg_data[L1_WAYS_W-1:0];
                    CFG_L2_OFF:  l2_off_reg  <= cfg_data[OFF_W-1:0];
                    CFG_L2_IDX:  l2_idx_reg  <= cfg_data[IDX_W-1:0];
                    CFG_L2_WAYS: l2_ways_reg <= cfg_data[L2_WAYS_W-1:0];
                    CFG_L2_FA:   l2_fa_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // geometry is registered from the configuration registers
    always_ff @(posedge aclk) begin
        geo_reg.g1 <= make_geo(l1_off_reg, l1_idx_reg, WAYS_W'(l1_ways_reg), L1_LINES);
        geo_reg.g2 <= make_geo(l2_off_reg, l2_idx_reg, l2_ways_reg, L2_LINES);
        geo_reg.fa <= l2_fa_reg;
    end

    assign geo    = geo_reg;
    assign geo_ok = geo_ok_reg;

    logic [ADDR_BITS-1:0] a, m1, m2, sh1, sh2, t1, t2;
    logic [A1-1:0]        s1, base1;
    logic [A2-1:0]        base2;
    logic [A1+WAYS_W-1:0] p1;
    logic [A2+WAYS_W-1:0] p2;

    always_comb begin
        a   = ADDR_BITS'(addr);
        m1  = (ADDR_BITS'(1) << geo_reg.g1.idx) - ADDR_BITS'(1);
        m2  = (ADDR_BITS'(1) << geo_reg.g2.idx) - ADDR_BITS'(1);
        sh1 = (a >> geo_reg.g1.off) & m1;
        sh2 = (a >> geo_reg.g2.off) & m2;
        t1  = a >> ({1'b0, geo_reg.g1.off} + {1'b0, geo_reg.g1.idx});
        t2  = a >> ({1'b0, geo_reg.g2.off} + {1'b0, geo_reg.g2.idx});
        s1  = sh1[A1-1:0];
        p1  = (A1+WAYS_W)'(sh1[A1-1:0]) * (A1+WAYS_W)'(geo_reg.g1.ways);
        p2  = (A2+WAYS_W)'(sh2[A2-1:0]) * (A2+WAYS_W)'(geo_reg.g2.ways);
        base1 = p1[A1-1:0];
        base2 = p2[A2-1:0];
        item  = {req_type, t1, s1, base1, t2, base2};
    end
endmodule

// File: rtl/tec_queue.sv
// ----------------------------------------------------------------------------
// tec_queue
// two-entry queue between the address front and the tag engine
// ----------------------------------------------------------------------------
module tec_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];
endmodule

// File: rtl/tec_back.sv
// ----------------------------------------------------------------------------
// tec_back
// tag engine: reset clear, way search, l2 probe, l1 fill and l2 victim insert
// ----------------------------------------------------------------------------
`include "two_level_exclusive_cache_tags_assert.svh"

module tec_back #(
    parameter int L1_LINES  = 256,
    parameter int L2_LINES  = 1024,
    parameter int ADDR_BITS = 32,
    parameter int A1        = 8,
    parameter int A2        = 10,
    parameter int ITEM_W    = 1 + 2 * ADDR_BITS + 2 * A1 + A2
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tec_pkg::cfg_geo_t          geo,
    input  logic                       q_valid,
    input  logic [ITEM_W-1:0]          q_data,
    output logic                       q_pop,
    output logic                       init_done,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [tec_pkg::STAT_W-1:0] m_l1_status,
    output logic [tec_pkg::STAT_W-1:0] m_l2_status
);
    import tec_pkg::*;

    localparam int AB    = ADDR_BITS;
    localparam int LW    = AB + 1;
    localparam int MAXL  = (L1_LINES > L2_LINES) ? L1_LINES : L2_LINES;
    localparam int CW    = $clog2(MAXL + 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_L1_RD  = 4'd2;
    localparam logic [3:0] S_L1_CK  = 4'd3;
    localparam logic [3:0] S_L2_RD  = 4'd4;
    localparam logic [3:0] S_L2_CK  = 4'd5;
    localparam logic [3:0] S_F1     = 4'd6;
    localparam logic [3:0] S_F1_PTR = 4'd7;
    localparam logic [3:0] S_F1_VIC = 4'd8;
    localparam logic [3:0] S_V_SPLT = 4'd9;
    localparam logic [3:0] S_V_BASE = 4'd10;
    localparam logic [3:0] S_F2_RD  = 4'd11;
    localparam logic [3:0] S_F2_CK  = 4'd12;
    localparam logic [3:0] S_F2_PTR = 4'd13;
    localparam logic [3:0] S_F2_RR  = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     clr_reg, clr_next;
    logic              req_reg, req_next;
    logic [AB-1:0]     t1_reg, t1_next, t2_reg, t2_next, vt_reg, vt_next;
    logic [A1-1:0]     s1_reg, s1_next, base1_reg, base1_next;
    logic [A2-1:0]     base2_reg, base2_next, s2v_reg, s2v_next;
    logic [WAYS_W-1:0] way_reg, way_next, free_reg, free_next, p_reg, p_next;
    logic              found_reg, found_next;
    logic [STAT_W-1:0] st1_reg, st1_next, st2_reg, st2_next;
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_l1_reg, out_l1_next, out_l2_reg, out_l2_next;

    logic          l1w_en, l2w_en, p1w_en, p2w_en;
    logic [A1-1:0] l1w_addr, l1r_addr, p1w_addr;
    logic [A2-1:0] l2w_addr, l2r_addr, p2w_addr;
    logic [LW-1:0] l1w_data, l2w_data, l1r_data, l2r_data;
    logic [L1_WAYS_W-1:0] p1w_data, p1r_data;
    logic [L2_WAYS_W-1:0] p2w_data, p2r_data;

    tec_ram #(.WIDTH(LW), .DEPTH(L1_LINES)) u_l1_line (
        .aclk(aclk), .wr_en(l1w_en), .wr_addr(l1w_addr), .wr_data(l1w_data),
        .rd_addr(l1r_addr), .rd_data(l1r_data)
    );
    tec_ram #(.WIDTH(L1_WAYS_W), .DEPTH(L1_LINES)) u_l1_ptr (
        .aclk(aclk), .wr_en(p1w_en), .wr_addr(p1w_addr), .wr_data(p1w_data),
        .rd_addr(s1_reg), .rd_data(p1r_data)
    );
    tec_ram #(.WIDTH(LW), .DEPTH(L2_LINES)) u_l2_line (
        .aclk(aclk), .wr_en(l2w_en), .wr_addr(l2w_addr), .wr_data(l2w_data),
        .rd_addr(l2r_addr), .rd_data(l2r_data)
    );
    tec_ram #(.WIDTH(L2_WAYS_W), .DEPTH(L2_LINES)) u_l2_ptr (
        .aclk(aclk), .wr_en(p2w_en), .wr_addr(p2w_addr), .wr_data(p2w_data),
        .rd_addr(s2v_reg), .rd_data(p2r_data)
    );

    logic [WAYS_W-1:0] way_inc, p1_fix, p2_fix, p_inc;
    logic [AB-1:0]     va, m2;
    logic [AB-1:0]     vsh;
    logic [A2+WAYS_W-1:0] vprod;
    logic              l1_valid_rd, l2_valid_rd;

    always_comb begin
        way_inc     = way_reg + WAYS_W'(1);
        p1_fix      = (WAYS_W'(p1r_data) >= geo.g1.ways) ? '0 : WAYS_W'(p1r_data);
        p2_fix      = (WAYS_W'(p2r_data) >= geo.g2.ways) ? '0 : WAYS_W'(p2r_data);
        p_inc       = p_reg + WAYS_W'(1);
        l1_valid_rd = l1r_data[LW-1];
        l2_valid_rd = l2r_data[LW-1];
        // victim address rebuilt from l1 tag and set, split by l2 geometry
        va    = (vt_reg << ({1'b0, geo.g1.off} + {1'b0, geo.g1.idx}))
              | (AB'(s1_reg) << geo.g1.off);
        m2    = (AB'(1) << geo.g2.idx) - AB'(1);
        vsh   = (va >> geo.g2.off) & m2;
        vprod = (A2+WAYS_W)'(s2v_reg) * (A2+WAYS_W)'(geo.g2.ways);
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        req_next       = req_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        vt_next        = vt_reg;
        s1_next        = s1_reg;
        base1_next     = base1_reg;
        base2_next     = base2_reg;
        s2v_next       = s2v_reg;
        way_next       = way_reg;
        free_next      = free_reg;
        p_next         = p_reg;
        found_next     = found_reg;
        st1_next       = st1_reg;
        st2_next       = st2_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_l1_next    = out_l1_reg;
        out_l2_next    = out_l2_reg;
        q_pop          = 1'b0;
        l1w_en   = 1'b0;
        l1w_addr = base1_reg + A1'(way_reg);
        l1w_data = {1'b1, t1_reg};
        l1r_addr = base1_reg + A1'(way_reg);
        l2w_en   = 1'b0;
        l2w_addr = base2_reg + A2'(way_reg);
        l2w_data = {1'b1, t2_reg};
        l2r_addr = base2_reg + A2'(way_reg);
        p1w_en   = 1'b0;
        p1w_addr = s1_reg;
        p1w_data = (p_inc == geo.g1.ways) ? '0 : p_inc[L1_WAYS_W-1:0];
        p2w_en   = 1'b0;
        p2w_addr = s2v_reg;
        p2w_data = (p_inc == geo.g2.ways) ? '0 : p_inc[L2_WAYS_W-1:0];

        unique case (state_reg)
            S_CLEAR: begin
                l1w_en   = (clr_reg < CW'(L1_LINES));
                p1w_en   = l1w_en;
                l2w_en   = (clr_reg < CW'(L2_LINES));
                p2w_en   = l2w_en;
                l1w_addr = clr_reg[A1-1:0];
                p1w_addr = clr_reg[A1-1:0];
                l2w_addr = clr_reg[A2-1:0];
                p2w_addr = clr_reg[A2-1:0];
                l1w_data = '0;
                l2w_data = '0;
                p1w_data = '0;
                p2w_data = '0;
                clr_next = clr_reg + CW'(1);
                if (clr_next == CW'(MAXL)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    {req_next, t1_next, s1_next, base1_next, t2_next, base2_next} = q_data;
                    way_next   = '0;
                    found_next = 1'b0;
                    st2_next   = ST_NONE;
                    state_next = S_L1_RD;
                end
            end
            S_L1_RD: state_next = S_L1_CK;
            S_L1_CK: begin
                if (l1_valid_rd && l1r_data[AB-1:0] == t1_reg) begin
                    st1_next   = req_reg ? ST_WRITE_HIT : ST_READ_HIT;
                    state_next = S_DONE;
                end else begin
                    if (!l1_valid_rd && !found_reg) begin
                        found_next = 1'b1;
                        free_next  = way_reg;
                    end
                    way_next = way_inc;
                    if (way_inc == geo.g1.ways) begin
                        st1_next   = req_reg ? ST_WRITE_MISS : ST_READ_MISS;
                        way_next   = '0;
                        state_next = S_L2_RD;
                    end else begin
                        state_next = S_L1_RD;
                    end
                end
            end
            S_L2_RD: state_next = S_L2_CK;
            S_L2_CK: begin
                if (l2_valid_rd && l2r_data[AB-1:0] == t2_reg) begin
                    if (req_reg) begin
                        st2_next   = ST_WRITE_HIT;
                        state_next = S_DONE;
                    end else begin
                        // exclusive: the line moves up to l1
                        st2_next   = ST_READ_HIT;
                        l2w_en     = 1'b1;
                        l2w_data   = '0;
                        state_next = S_F1;
                    end
                end else begin
                    way_next = way_inc;
                    if (way_inc == geo.g2.ways) begin
                        st2_next   = req_reg ? ST_WRITE_MISS : ST_READ_MISS;
                        state_next = req_reg ? S_DONE : S_F1;
                    end else begin
                        state_next = S_L2_RD;
                    end
                end
            end
            S_F1: begin
                if (found_reg) begin
                    l1w_en     = 1'b1;
                    l1w_addr   = base1_reg + A1'(free_reg);
                    state_next = S_DONE;
                end else begin
                    state_next = S_F1_PTR;
                end
            end
            S_F1_PTR: begin
                p_next     = p1_fix;
                l1r_addr   = base1_reg + A1'(p1_fix);
                state_next = S_F1_VIC;
            end
            S_F1_VIC: begin
                l1w_en     = 1'b1;
                l1w_addr   = base1_reg + A1'(p_reg);
                p1w_en     = 1'b1;
                vt_next    = l1r_data[AB-1:0];
                state_next = l1_valid_rd ? S_V_SPLT : S_DONE;
            end
            S_V_SPLT: begin
                s2v_next   = vsh[A2-1:0];
                t2_next    = va >> ({1'b0, geo.g2.off} + {1'b0, geo.g2.idx});
                state_next = S_V_BASE;
            end
            S_V_BASE: begin
                base2_next = vprod[A2-1:0];
                way_next   = '0;
                state_next = geo.fa ? S_F2_PTR : S_F2_RD;
            end
            S_F2_RD: state_next = S_F2_CK;
            S_F2_CK: begin
                if (!l2_valid_rd) begin
                    l2w_en     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    way_next   = way_inc;
                    state_next = (way_inc == geo.g2.ways) ? S_F2_PTR : S_F2_RD;
                end
            end
            S_F2_PTR: state_next = S_F2_RR;
            S_F2_RR: begin
                // displaced l2 line is dropped
                p_next     = p2_fix;
                l2w_en     = 1'b1;
                l2w_addr   = base2_reg + A2'(p2_fix);
                p2w_en     = 1'b1;
                p2w_data   = ((p2_fix + WAYS_W'(1)) == geo.g2.ways) ? '0
                           : L2_WAYS_W'(p2_fix + WAYS_W'(1));
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_l1_next    = st1_reg;
                    out_l2_next    = st2_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        vt_reg     <= vt_next;
        s1_reg     <= s1_next;
        base1_reg  <= base1_next;
        base2_reg  <= base2_next;
        s2v_reg    <= s2v_next;
        way_reg    <= way_next;
        free_reg   <= free_next;
        p_reg      <= p_next;
        found_reg  <= found_next;
        st1_reg    <= st1_next;
        st2_reg    <= st2_next;
        out_l1_reg <= out_l1_next;
        out_l2_reg <= out_l2_next;
    end

    assign init_done   = (state_reg != S_CLEAR);
    assign m_valid     = out_valid_reg;
    assign m_l1_status = out_l1_reg;
    assign m_l2_status = out_l2_reg;

    `TEC_ASSERT_IMPL(a_l2_probe_on_miss, aclk, aresetn, out_valid_reg,
        ((out_l1_reg == ST_READ_HIT || out_l1_reg == ST_WRITE_HIT) ==
         (out_l2_reg == ST_NONE)))
    `TEC_ASSERT_IMPL(a_l1_addr_range, aclk, aresetn, l1w_en,
        (32'(l1w_addr) < 32'(L1_LINES)))
    `TEC_ASSERT_NEXT(a_pop_starts_search, aclk, aresetn, q_pop,
        (state_reg == S_L1_RD))
    `TEC_ASSERT_IMPL(a_no_pop_in_clear, aclk, aresetn, q_pop, init_done)
endmodule

// File: rtl/two_level_exclusive_cache_tags.sv
// ----------------------------------------------------------------------------
// two_level_exclusive_cache_tags
// tag and valid arrays of an exclusive l1/l2 pair with round-robin refill
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tdata addr, tuser req_type
//  m_axis    out  m_axis_tvalid/tready   tdata l1_status, l2_status
//  cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  an access goes through the pop of its word, a read and check per l1 way searched,
//  a read and check per l2 way on an l1 miss and, on a read, the l1 fill and the
//  victim insert into l2 before its result is registered; the single engine
//  walking the tag rams takes the next word only after that result is registered
//  after reset a clearing pass over every line of both levels runs before
//  the first word is taken; s_axis_tready also drops in the cycle after a
//  configuration write
//  a two-word queue and the output register let either side stall alone
module two_level_exclusive_cache_tags #(
    parameter int L1_LINES  = tec_pkg::DEF_L1_LINES,
    parameter int L2_LINES  = tec_pkg::DEF_L2_LINES,
    parameter int ADDR_BITS = tec_pkg::DEF_ADDR_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,   // [31:0] addr
    input  logic [0:0]                   s_axis_tuser,   // [0] req_type
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,   // [2:0] l1_status, [5:3] l2_status
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tec_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tec_pkg::*;

    localparam int A1     = (L1_LINES > 1) ? $clog2(L1_LINES) : 1;
    localparam int A2     = (L2_LINES > 1) ? $clog2(L2_LINES) : 1;
    localparam int ITEM_W = 1 + 2 * ADDR_BITS + 2 * A1 + A2;

    cfg_geo_t          geo;
    logic              geo_ok, q_full, q_valid, q_pop, init_done;
    logic [ITEM_W-1:0] item, q_data;
    logic [STAT_W-1:0] l1_st, l2_st;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full && init_done && geo_ok;

    tec_front #(
        .L1_LINES(L1_LINES), .L2_LINES(L2_LINES), .ADDR_BITS(ADDR_BITS),
        .A1(A1), .A2(A2), .ITEM_W(ITEM_W)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_type(s_axis_tuser[0]), .addr(s_axis_tdata),
        .item(item), .geo(geo), .geo_ok(geo_ok)
    );

    tec_queue #(.WIDTH(ITEM_W)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(s_axis_tvalid && s_axis_tready), .push_data(item), .full(q_full),
        .pop(q_pop), .not_empty(q_valid), .pop_data(q_data)
    );

    tec_back #(
        .L1_LINES(L1_LINES), .L2_LINES(L2_LINES), .ADDR_BITS(ADDR_BITS),
        .A1(A1), .A2(A2), .ITEM_W(ITEM_W)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .geo(geo),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .init_done(init_done),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .m_l1_status(l1_st), .m_l2_status(l2_st)
    );

    assign m_axis_tdata = {2'b00, l2_st, l1_st};
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the exclusive l1/l2 tag block against a cycle-free predictor of the
// tag, valid and round-robin arrays; geometry is swept through several
// settings including the clamping extremes, with random stalls on both sides
// ----------------------------------------------------------------------------
module testbench;
    import tec_pkg::*;

    class cache_scoreboard;
        // level 0 is l1 (first 256 lines used), level 1 is l2
        bit [31:0]   tags[2][1024];
        bit          vld[2][1024];
        int unsigned ptr[2][1024];
        int unsigned regs[7];
        bit [5:0]    pending[$];
        int          errors;

        function new();
            regs = '{6, 6, 4, 6, 8, 4, 0};
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
            case (idx)
                CFG_L1_OFF:  regs[0] = v & 4'hF;
                CFG_L1_IDX:  regs[1] = v & 4'hF;
                CFG_L1_WAYS: regs[2] = v & 9'h1FF;
                CFG_L2_OFF:  regs[3] = v & 4'hF;
                CFG_L2_IDX:  regs[4] = v & 4'hF;
                CFG_L2_WAYS: regs[5] = v & 11'h7FF;
                CFG_L2_FA:   regs[6] = v & 1;
                default: ;
            endcase
        endfunction

        function void shape(int unsigned idx_in, int unsigned ways_in, int unsigned cap,
                            output int unsigned idx_out, output int unsigned ways_out);
            ways_out = (ways_in < 1) ? 1 : ways_in;
            if (ways_out > cap) ways_out = cap;
            idx_out = idx_in;
            while (idx_out > 0 && (longint'(ways_out) << idx_out) > cap) idx_out--;
        endfunction

        function int find(int lv, longint unsigned set, int unsigned ways, bit [31:0] tag);
            for (int w = 0; w < ways; w++)
                if (vld[lv][set*ways+w] && tags[lv][set*ways+w] == tag) return w;
            return -1;
        endfunction

        function bit fill(int lv, longint unsigned set, int unsigned ways, bit [31:0] tag,
                          bit rr_only, output bit [31:0] victim);
            int unsigned p;
            longint unsigned line;
            bit had;
            victim = '0;
            if (!rr_only) begin
                for (int w = 0; w < ways; w++) begin
                    line = set*ways + w;
                    if (!vld[lv][line]) begin
                        tags[lv][line] = tag;
                        vld[lv][line] = 1'b1;
                        return 1'b0;
                    end
                end
            end
            p = ptr[lv][set];
            if (p >= ways) p = 0;   // stale pointer after a reconfiguration
            line = set*ways + p;
            had = vld[lv][line];
            victim = tags[lv][line];
            tags[lv][line] = tag;
            vld[lv][line] = 1'b1;
            p++;
            if (p >= ways) p = 0;
            ptr[lv][set] = p;
            return had;
        endfunction

        function void note_access(bit wr, bit [31:0] a);
            int unsigned i1, w1, i2, w2, o1, o2;
            longint unsigned s1, s2, va;
            bit [31:0] t1, t2, vt, dropped;
            logic [2:0] st1, st2;
            int hit2;
            o1 = regs[0];
            o2 = regs[3];
            shape(regs[1], regs[2], 256, i1, w1);
            shape(regs[4], regs[5], 1024, i2, w2);
            s1 = (longint'(a) >> o1) & ((64'd1 << i1) - 1);
            t1 = a >> (o1 + i1);
            s2 = (longint'(a) >> o2) & ((64'd1 << i2) - 1);
            t2 = a >> (o2 + i2);
            st2 = ST_NONE;
            if (find(0, s1, w1, t1) >= 0) begin
                st1 = wr ? ST_WRITE_HIT : ST_READ_HIT;
            end else begin
                st1 = wr ? ST_WRITE_MISS : ST_READ_MISS;
                hit2 = find(1, s2, w2, t2);
                if (wr) begin
                    st2 = (hit2 >= 0) ? ST_WRITE_HIT : ST_WRITE_MISS;
                end else begin
                    if (hit2 >= 0) begin
                        st2 = ST_READ_HIT;
                        vld[1][s2*w2 + hit2] = 1'b0;
                    end else begin
                        st2 = ST_READ_MISS;
                    end
                    if (fill(0, s1, w1, t1, 1'b0, vt)) begin
                        // victim address rebuilt from tag and set, then split for l2
                        va = ((longint'(vt) << (o1 + i1)) | (s1 << o1)) & 64'hFFFF_FFFF;
                        void'(fill(1, (va >> o2) & ((64'd1 << i2) - 1), w2,
                                   32'(va >> (o2 + i2)), regs[6] != 0, dropped));
                    end
                end
            end
            pending.push_back({st2, st1});
        endfunction

        function void check_result(logic [7:0] d);
            bit [5:0] e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[2:0] !== e[2:0]) begin
                $display("%0t: l1_status expected %0d actual %0d", $time, e[2:0], d[2:0]);
                errors++;
            end
            if (d[5:3] !== e[5:3]) begin
                $display("%0t: l2_status expected %0d actual %0d", $time, e[5:3], d[5:3]);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cache_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int              stall_left = 0;
    int              quiet = 0;
    bit [31:0]       addr_pool[16];

    two_level_exclusive_cache_tags u_top (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(v);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, v);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned l1o, l1i, l1w, l2o, l2i, l2w, fa);
        // idle first: every expected word back, then let the engine settle
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_write(CFG_L1_OFF, l1o);
        cfg_write(CFG_L1_IDX, l1i);
        cfg_write(CFG_L1_WAYS, l1w);
        cfg_write(CFG_L2_OFF, l2o);
        cfg_write(CFG_L2_IDX, l2i);
        cfg_write(CFG_L2_WAYS, l2w);
        cfg_write(CFG_L2_FA, fa);
        @(posedge aclk);
    endtask

    task automatic send_access(bit wr, bit [31:0] a);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= a;
        s_axis_tuser  <= wr;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_access(wr, a);
    endtask

    task automatic random_accesses(int n);
        bit [31:0] a;
        for (int k = 0; k < 16; k++) addr_pool[k] = $urandom & 32'h000F_F3C0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) a = $urandom;
            else a = addr_pool[$urandom_range(0, 15)] ^ ($urandom & 32'h3F);
            send_access($urandom_range(0, 3) == 0, a);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, hit and miss of both kinds, set overflow, l2 hit
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b1, 32'h0000_0000);
        send_access(1'b1, 32'hFFFF_FFFF);
        send_access(1'b0, 32'hFFFF_FFFF);
        send_access(1'b1, 32'hFFFF_FFC0);
        for (int k = 1; k <= 5; k++) send_access(1'b0, k << 12);
        send_access(1'b1, 32'h0000_1000);
        send_access(1'b0, 32'h0000_1000);
        send_access(1'b1, 32'h0000_1000);
        send_access(1'b0, 32'h0000_2000);
        send_access(1'b0, 32'h0000_0000);
        send_access(1'b0, 32'hAAAA_AAAA);
        send_access(1'b0, 32'h5555_5555);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);

        set_geometry(0, 0, 1, 0, 0, 1, 0);
        random_accesses(100);
        set_geometry(12, 8, 2, 12, 10, 1, 1);
        random_accesses(100);
        set_geometry(4, 15, 0, 4, 15, 0, 0);
        random_accesses(100);
        set_geometry(6, 2, 16, 5, 4, 16, 1);
        random_accesses(120);
        // widest ways: slow walks, so only a few words
        set_geometry(3, 1, 511, 3, 0, 2047, 0);
        random_accesses(30);
        set_geometry(6, 6, 4, 6, 8, 4, 0);
        random_accesses(130);
        set_geometry(15, 3, 3, 2, 5, 5, 1);
        idle_on = 1'b0;
        random_accesses(150);

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/tec_pkg.sv
rtl/tec_ram.sv
rtl/tec_front.sv
rtl/tec_queue.sv
rtl/tec_back.sv
rtl/two_level_exclusive_cache_tags.sv
tb/testbench.sv
